// File: src/amq_pkg.sv
package amq_pkg;

    localparam int ROW_MAX_DEF = 512;
    localparam int LANES_DEF   = 8;
    localparam int SAMPLE_W    = 24;
    localparam int MAG_W       = 23;
    localparam int PACK_W      = 64;
    localparam int LCNT_W      = 4;
    localparam int SCALE_W     = 25;
    localparam int QMAX        = 127;
    localparam int NUM_W       = 32;
    localparam int DEN_W       = 24;
    localparam int QUO_W       = 8;

    typedef struct packed {
        logic                 last;
        logic [MAG_W-1:0]     absmax;
        logic                 overflow;
        logic [9:0]           count;
    } amq_row_t;

    function automatic logic [MAG_W-1:0] mag_sat(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] n;
        begin
            n = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
            if (n[SAMPLE_W-1])
            begin
                mag_sat = {MAG_W{1'b1}};
            end
            else
            begin
                mag_sat = n[MAG_W-1:0];
            end
        end
    endfunction

endpackage

// File: src/absmax_int8_row_quantizer.sv
// Per-row symmetric absmax int8 quantizer.
// Input channel: valid/stall with sample (signed Q8.16) and last_in.
// Samples are stored one per cycle while the row is loading; stall is low.
// The transfer carrying last_in starts the emit phase; stall stays high
// until every result of the row has been taken into the output register.
// Emit phase: the scale is found first (shift-sum estimate, then compare
// and subtract), then each element goes through RAM read, an 8-step restoring
// divide and pack; the divide is skipped when the row is all zero.
// Output channel: valid/stall with quant_pack (up to LANES int8 lanes),
// lane_count, row_scale (unsigned Q1.24), row_overflow and last_out.
// One result per LANES elements; last_out marks the row's final result.
// Samples past ROW_MAX are dropped and raise row_overflow.
// When the receiver stalls, the held result stays stable and the emit
// sequencer waits at the end of the next group before overwriting it.
// Reset (rst_n low, asynchronous) empties the row and the output register.
// The row RAM has no reset; only entries written in the current row are read.
module absmax_int8_row_quantizer #(
    parameter int ROW_MAX = amq_pkg::ROW_MAX_DEF,
    parameter int LANES   = amq_pkg::LANES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [amq_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          last_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [amq_pkg::PACK_W-1:0]    quant_pack,
    output logic [amq_pkg::LCNT_W-1:0]    lane_count,
    output logic [amq_pkg::SCALE_W-1:0]   row_scale,
    output logic                          row_overflow,
    output logic                          last_out
);
    import amq_pkg::*;

    logic                       wr_en;
    logic [$clog2(ROW_MAX)-1:0] wr_addr;
    logic [SAMPLE_W-1:0]        wr_data;
    logic [$clog2(ROW_MAX)-1:0] rd_addr;
    logic [SAMPLE_W-1:0]        rd_data;
    logic                       row_valid;
    amq_row_t                   row_info;
    logic                       row_busy;

    amq_front #(.ROW_MAX(ROW_MAX)) u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .sample(sample),
        .last_in(last_in), .stall(in_stall), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(wr_data), .row_valid(row_valid), .row_info(row_info),
        .row_busy(row_busy)
    );

    amq_ram #(.WIDTH(SAMPLE_W), .DEPTH(ROW_MAX)) u_ram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    amq_back #(.ROW_MAX(ROW_MAX), .LANES(LANES)) u_back (
        .clk(clk), .rst_n(rst_n), .row_valid(row_valid), .row_info(row_info),
        .row_busy(row_busy), .rd_addr(rd_addr), .rd_data(rd_data),
        .valid(out_valid), .stall(out_stall), .quant_pack(quant_pack),
        .lane_count(lane_count), .row_scale(row_scale),
        .row_overflow(row_overflow), .last_out(last_out)
    );
endmodule

// File: src/amq_ram.sv
module amq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// File: src/amq_front.sv
module amq_front #(
    parameter int ROW_MAX = amq_pkg::ROW_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    input  logic [amq_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          last_in,
    output logic                          stall,
    output logic                          wr_en,
    output logic [$clog2(ROW_MAX)-1:0]    wr_addr,
    output logic [amq_pkg::SAMPLE_W-1:0]  wr_data,
    output logic                          row_valid,
    output amq_pkg::amq_row_t             row_info,
    input  logic                          row_busy
);
    import amq_pkg::*;

    localparam int CNT_W = $clog2(ROW_MAX + 1);

    logic [CNT_W-1:0] count_reg;
    logic [MAG_W-1:0] absmax_reg;
    logic             drop_reg;
    logic             accept;
    logic             room;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] amax_new;

    assign stall   = row_busy;
    assign accept  = valid && !row_busy;
    assign room    = count_reg < CNT_W'(ROW_MAX);
    assign mag     = mag_sat(sample);
    assign wr_en   = accept && room;
    assign wr_addr = count_reg[$clog2(ROW_MAX)-1:0];
    assign wr_data = sample;
    assign amax_new = (room && mag > absmax_reg) ? mag : absmax_reg;

    assign row_valid         = accept && last_in;
    assign row_info.last     = 1'b1;
    assign row_info.absmax   = amax_new;
    assign row_info.overflow = drop_reg || !room;
    assign row_info.count    = 10'(count_reg + (room ? CNT_W'(1) : CNT_W'(0)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            absmax_reg <= '0;
            drop_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_in)
            begin
                count_reg  <= '0;
                absmax_reg <= '0;
                drop_reg   <= 1'b0;
            end
            else
            begin
                absmax_reg <= amax_new;
                if (room)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ROW_MAX)) else $error("count over depth");
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        !room |-> !wr_en) else $error("write when full");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |=> count_reg == '0) else $error("count not cleared");
`endif
endmodule

// File: src/amq_back.sv
module amq_back #(
    parameter int ROW_MAX = amq_pkg::ROW_MAX_DEF,
    parameter int LANES   = amq_pkg::LANES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          row_valid,
    input  amq_pkg::amq_row_t             row_info,
    output logic                          row_busy,
    output logic [$clog2(ROW_MAX)-1:0]    rd_addr,
    input  logic [amq_pkg::SAMPLE_W-1:0]  rd_data,
    output logic                          valid,
    input  logic                          stall,
    output logic [amq_pkg::PACK_W-1:0]    quant_pack,
    output logic [amq_pkg::LCNT_W-1:0]    lane_count,
    output logic [amq_pkg::SCALE_W-1:0]   row_scale,
    output logic                          row_overflow,
    output logic                          last_out
);
    import amq_pkg::*;

    localparam int AW = $clog2(ROW_MAX);

    typedef enum logic [2:0] {S_IDLE, S_SCALE, S_READ, S_WAIT, S_DIV, S_OUT} state_t;

    state_t            state_reg;
    logic [9:0]        total_reg;
    logic [9:0]        idx_reg;
    logic [LCNT_W-1:0] lane_reg;
    logic [MAG_W-1:0]  amax_reg;
    logic              ovf_reg;
    logic              neg_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [DEN_W:0]    den_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [4:0]        bit_reg;
    logic [NUM_W+1:0]  snum_reg;
    logic [PACK_W-1:0] pack_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic              out_valid_reg;
    logic              out_last_reg;
    logic [LCNT_W-1:0] out_lanes_reg;
    logic [PACK_W-1:0] out_pack_reg;
    logic [SCALE_W-1:0] out_scale_reg;
    logic              out_ovf_reg;
    logic [MAG_W-1:0]  mag;
    logic [NUM_W-1:0]  num;
    logic [7:0]        qbyte;
    logic [QUO_W-1:0]  qsat;
    logic              grp_last;
    logic              emit;
    logic [SCALE_W-1:0] scale_est;

    assign row_busy     = state_reg != S_IDLE;
    assign rd_addr      = AW'(idx_reg);
    assign valid        = out_valid_reg;
    assign quant_pack   = out_pack_reg;
    assign lane_count   = out_lanes_reg;
    assign row_scale    = out_scale_reg;
    assign row_overflow = out_ovf_reg;
    assign last_out     = out_last_reg;

    assign mag   = mag_sat(rd_data);
    assign num   = NUM_W'(254 * 32'(mag)) + NUM_W'(amax_reg);
    assign qsat  = (quo_reg > QUO_W'(QMAX)) ? QUO_W'(QMAX) : quo_reg;
    assign qbyte = neg_reg ? (~qsat + 1'b1) : qsat;
    assign grp_last = (lane_reg == LCNT_W'(LANES - 1)) || (idx_reg + 10'd1 == total_reg);
    assign emit  = (state_reg == S_OUT) && grp_last && (!out_valid_reg || !stall);

    // scale = floor(M / 127) with M = absmax*256 + 63; the shift sum is low by at most 4
    assign scale_est = SCALE_W'((snum_reg >> 7) + (snum_reg >> 14) +
                                (snum_reg >> 21) + (snum_reg >> 28));

    // FSM; restoring divide, one quotient bit per cycle; quotient fits 8 bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            idx_reg       <= '0;
            lane_reg      <= '0;
            amax_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_last_reg  <= 1'b0;
            out_lanes_reg <= '0;
            out_scale_reg <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !stall && !emit)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (row_valid)
                    begin
                        total_reg <= row_info.count;
                        amax_reg  <= row_info.absmax;
                        ovf_reg   <= row_info.overflow;
                        idx_reg   <= '0;
                        lane_reg  <= '0;
                        pack_reg  <= '0;
                        snum_reg  <= 34'({row_info.absmax, 8'h3F});
                        quo_reg   <= '0;
                        bit_reg   <= 5'd1;
                        scale_reg <= '0;
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    if (bit_reg != 5'd0)
                    begin
                        scale_reg <= scale_est;
                        snum_reg  <= snum_reg - (34'(scale_est) << 7) + 34'(scale_est);
                        bit_reg   <= 5'd0;
                    end
                    else if (snum_reg >= 34'd127)
                    begin
                        snum_reg  <= snum_reg - 34'd127;
                        scale_reg <= scale_reg + SCALE_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    neg_reg   <= rd_data[SAMPLE_W-1];
                    rem_reg   <= num;
                    den_reg   <= {amax_reg, 1'b0};
                    quo_reg   <= '0;
                    bit_reg   <= 5'd7;
                    state_reg <= (amax_reg == '0) ? S_OUT : S_DIV;
                end
                S_DIV:
                begin
                    if ((rem_reg >> bit_reg) >= NUM_W'(den_reg))
                    begin
                        rem_reg <= rem_reg - (NUM_W'(den_reg) << bit_reg);
                        quo_reg[bit_reg[2:0]] <= 1'b1;
                    end
                    if (bit_reg == 5'd0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 5'd1;
                    end
                end
                S_OUT:
                begin
                    if (!grp_last || emit)
                    begin
                        if (grp_last)
                        begin
                            out_pack_reg  <= pack_reg |
                                (PACK_W'(qbyte) << (8 * lane_reg));
                            out_lanes_reg <= lane_reg + LCNT_W'(1);
                            out_last_reg  <= idx_reg + 10'd1 == total_reg;
                            out_scale_reg <= scale_reg;
                            out_ovf_reg   <= ovf_reg;
                            out_valid_reg <= 1'b1;
                            pack_reg      <= '0;
                            lane_reg      <= '0;
                        end
                        else
                        begin
                            pack_reg <= pack_reg | (PACK_W'(qbyte) << (8 * lane_reg));
                            lane_reg <= lane_reg + LCNT_W'(1);
                        end
                        if (idx_reg + 10'd1 == total_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 10'd1;
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (lane_count != '0 && lane_count <= LCNT_W'(LANES)))
        else $error("bad lane count");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE && state_reg != S_SCALE |-> idx_reg < total_reg)
        else $error("index past row");
    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> state_reg == S_IDLE) else $error("row while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && stall |=> valid && $stable(quant_pack) && $stable(row_scale) &&
        $stable(row_overflow) && $stable(last_out)) else $error("stalled transfer changed");
`endif
endmodule

// File: verif/absmax_int8_row_quantizer_test.sv
module absmax_int8_row_quantizer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import amq_pkg::*;

    typedef struct {
        logic [PACK_W-1:0]  pack;
        logic [LCNT_W-1:0]  lanes;
        logic [SCALE_W-1:0] scale;
        logic               ovf;
        logic               last;
    } quant_result_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] s;
        logic                l;
        logic                typed;
        logic [PACK_W-1:0]   pack;
        logic [SCALE_W-1:0]  scale;
    } stim_row_t;

    localparam int N_DIRECTED = 25;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{24'h000000, 1'b1, 1'b1, 64'h0,  25'd0},
        '{24'h000001, 1'b1, 1'b1, 64'h7F, 25'd2},
        '{24'hFFFFFF, 1'b1, 1'b1, 64'h81, 25'd2},
        '{24'h7FFFFF, 1'b1, 1'b0, 64'h0,  25'd0},
        '{24'h800000, 1'b1, 1'b0, 64'h0,  25'd0},
        '{24'h000002, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h000001, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'hFFFFFF, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h000000, 1'b1, 1'b0, 64'h0,  25'd0},
        '{24'h800000, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h7FFFFF, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h000000, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h000001, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'hFFFFFF, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h400000, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'hC00000, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h3FFFFF, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h555555, 1'b1, 1'b0, 64'h0,  25'd0},
        '{24'h000000, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h000000, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h000000, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h000000, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h000000, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h000000, 1'b0, 1'b0, 64'h0,  25'd0},
        '{24'h000000, 1'b1, 1'b0, 64'h0,  25'd0}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SAMPLE_W-1:0] sample;
    logic                last_in;
    logic                out_valid;
    logic                out_stall;
    logic [PACK_W-1:0]   quant_pack;
    logic [LCNT_W-1:0]   lane_count;
    logic [SCALE_W-1:0]  row_scale;
    logic                row_overflow;
    logic                last_out;

    absmax_int8_row_quantizer DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last_in(last_in),
        .out_valid(out_valid), .out_stall(out_stall), .quant_pack(quant_pack),
        .lane_count(lane_count), .row_scale(row_scale), .row_overflow(row_overflow),
        .last_out(last_out)
    );

    logic [SAMPLE_W-1:0] row_copy [ROW_MAX_DEF];
    logic [MAG_W-1:0]    absmax_now;
    int unsigned         stored_count;
    logic                dropped_now;
    quant_result_t       expected_q [$];
    int unsigned         mismatches;
    int unsigned         sent_count;
    int unsigned         result_count;
    int unsigned         row_count;
    int unsigned         stall_left;
    bit                  quiet_phase;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W:0] m;
        m = s[SAMPLE_W-1] ? ({1'b0, ~s} + 25'd1) : {1'b0, s};
        if (m > 25'd8388607)
            m = 25'd8388607;
        return m[MAG_W-1:0];
    endfunction

    function automatic logic [7:0] quantize(input logic [SAMPLE_W-1:0] s,
                                            input logic [MAG_W-1:0] amax);
        longint unsigned q;
        if (amax == 0)
            return 8'd0;
        q = (254 * longint'(magnitude(s)) + amax) / (2 * longint'(amax));
        if (q > QMAX)
            q = QMAX;
        return s[SAMPLE_W-1] ? 8'(256 - q) : 8'(q);
    endfunction

    function automatic void predict_transfer(input logic [SAMPLE_W-1:0] s, input logic l);
        quant_result_t r;
        logic [SCALE_W-1:0] scale;
        int unsigned n;
        if (stored_count < ROW_MAX_DEF)
        begin
            row_copy[stored_count] = s;
            stored_count++;
            if (magnitude(s) > absmax_now)
                absmax_now = magnitude(s);
        end
        else
        begin
            dropped_now = 1'b1;
        end
        if (!l)
            return;
        scale = SCALE_W'((longint'(absmax_now) * 512 + 127) / 254);
        for (int unsigned i = 0; i < stored_count; i += LANES_DEF)
        begin
            n = (stored_count - i > LANES_DEF) ? LANES_DEF : stored_count - i;
            r.pack = '0;
            for (int unsigned k = 0; k < n; k++)
                r.pack[8*k +: 8] = quantize(row_copy[i+k], absmax_now);
            r.lanes = LCNT_W'(n);
            r.scale = scale;
            r.ovf   = dropped_now;
            r.last  = (i + LANES_DEF >= stored_count);
            expected_q.push_back(r);
        end
        absmax_now = '0;
        stored_count = 0;
        dropped_now = 1'b0;
        row_count++;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(input logic [SAMPLE_W-1:0] s, input logic l,
                        input bit typed, input stim_row_t row);
        int unsigned gap;
        quant_result_t r;
        in_valid <= 1'b1;
        sample   <= s;
        last_in  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_transfer(s, l);
        if (typed)
        begin
            void'(expected_q.pop_back());
            r.pack = row.pack;
            r.lanes = 4'd1;
            r.scale = row.scale;
            r.ovf = 1'b0;
            r.last = 1'b1;
            expected_q.push_back(r);
        end
        sent_count++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample(input int unsigned mode);
        case (mode)
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($urandom_range(0, 600)) - 24'd300;
            2: return 24'h000000;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 24'h7FFFFF;
                    1: return 24'h800000;
                    2: return 24'h800001;
                    3: return 24'h000000;
                    default: return SAMPLE_W'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic send_row(input int unsigned len);
        int unsigned mode;
        stim_row_t none;
        none = '0;
        mode = $urandom_range(0, 19);
        mode = (mode < 10) ? 0 : (mode < 15) ? 1 : (mode < 16) ? 2 : 3;
        for (int unsigned i = 0; i < len; i++)
            send(random_sample(mode), i == len - 1, 1'b0, none);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: pack=%h lanes=%0d",
                                 quant_pack, lane_count);
                end
                else
                begin
                    quant_result_t e;
                    e = expected_q.pop_front();
                    if (quant_pack !== e.pack || lane_count !== e.lanes ||
                        row_scale !== e.scale || row_overflow !== e.ovf ||
                        last_out !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: exp pack=%h lanes=%0d scale=%0d ovf=%b last=%b",
                                     e.pack, e.lanes, e.scale, e.ovf, e.last);
                            $display("          got pack=%h lanes=%0d scale=%0d ovf=%b last=%b",
                                     quant_pack, lane_count, row_scale, row_overflow,
                                     last_out);
                        end
                    end
                end
            end
            if (quiet_phase)
            begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                stall_left = pick_gap();
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        absmax_now = '0;
        stored_count = 0;
        dropped_now = 1'b0;
        mismatches = 0;
        sent_count = 0;
        result_count = 0;
        row_count = 0;
        stall_left = 0;
        quiet_phase = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        last_in = 1'b0;
        out_stall = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send(DIRECTED[i].s, DIRECTED[i].l, DIRECTED[i].typed, DIRECTED[i]);

        while (sent_count < 440)
        begin
            quiet_phase = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 9))
                0, 1: send_row($urandom_range(17, 64));
                2:    send_row($urandom_range(65, 120));
                default: send_row($urandom_range(1, 16));
            endcase
        end
        quiet_phase = 1'b0;
        send_row(8);

        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d rows, %0d sample transfers, %0d result transfers",
                 row_count, sent_count, result_count);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
